/* hw/rtl/udpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udpd_pkg
// Shared types and constants for the udp port dispatch table.
// ----------------------------------------------------------------------------
package udpd_pkg;

    localparam int TABLE_DEPTH   = 10;
    localparam int ADDR_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int COUNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_IDX_W   = 4;
    localparam int OUT_COUNT_W   = 4;
    localparam int CMP_W         = (COUNT_W > ENTRY_IDX_W) ? COUNT_W : ENTRY_IDX_W;
    localparam int UDP_HDR_BYTES = 8;

    typedef enum logic [1:0] {
        REQ_REGISTER = 2'd0,
        REQ_REMOVE   = 2'd1,
        REQ_ROUTE    = 2'd2,
        REQ_NONE     = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        STS_REGISTERED = 4'd0,
        STS_IN_USE     = 4'd1,
        STS_FULL       = 4'd2,
        STS_REMOVED    = 4'd3,
        STS_BAD_INDEX  = 4'd4,
        STS_FORWARDED  = 4'd5,
        STS_TOO_SHORT  = 4'd6,
        STS_BAD_CSUM   = 4'd7,
        STS_NO_SERVER  = 4'd8,
        STS_EMPTY      = 4'd9
    } status_t;

    typedef enum logic {
        CS_IDLE,
        CS_EXEC
    } ctrl_state_t;

    typedef struct packed {
        req_t                   req_type;
        logic [15:0]            port;
        logic [7:0]             handle;
        logic [ENTRY_IDX_W-1:0] entry_index;
        logic [15:0]            recv_length;
        logic [3:0]             ip_header_words;
        logic [15:0]            udp_length;
        logic [15:0]            rx_checksum;
        logic [15:0]            calc_checksum;
    } udpd_in_t;

    typedef struct packed {
        status_t                status;
        logic [7:0]             conflict_handle;
        logic [7:0]             target_handle;
        logic [15:0]            payload_length;
        logic [OUT_COUNT_W-1:0] entry_count;
    } udpd_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic commit;
    } udpd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic has_result;
    } udpd_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/udpd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udpd_ctrl
// Request sequencer: captures a transaction, then commits it once the
// result register is free.
// ----------------------------------------------------------------------------
module udpd_ctrl
    import udpd_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    input  wire udpd_sts_t dp_sts,
    output udpd_cmd_t      cmd
);

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CS_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        cmd.load     = 1'b0;
        cmd.commit   = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            CS_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC: begin
                // wait until the result register can take a new transaction
                if (!m_valid_reg || m_ready) begin
                    cmd.commit = 1'b1;
                    state_next = CS_IDLE;
                    if (dp_sts.has_result) begin
                        m_valid_next = 1'b1;
                    end
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTH
    a_load_then_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == CS_EXEC)
        else $error("captured transaction did not reach execute");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !cmd.commit)
        else $error("commit while result still pending");

    a_commit_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && dp_sts.has_result) |=> m_valid_reg)
        else $error("committed result not presented");
`endif

endmodule
`default_nettype wire

/* hw/rtl/udpd_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udpd_datapath
// Port/handle table, parallel lookup, compaction shift, route checks and
// the result register.
// ----------------------------------------------------------------------------
module udpd_datapath
    import udpd_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire udpd_cmd_t cmd,
    input  wire udpd_in_t  s_data,
    output udpd_sts_t      dp_sts,
    output udpd_out_t      m_data
);

    udpd_in_t           req_reg;
    udpd_out_t          out_reg, out_next;
    logic [15:0]        port_store_reg [TABLE_DEPTH];
    logic [15:0]        port_store_next [TABLE_DEPTH];
    logic [7:0]         handle_store_reg [TABLE_DEPTH];
    logic [7:0]         handle_store_next [TABLE_DEPTH];
    logic [COUNT_W-1:0] count_reg, count_next;

    logic [7:0]  hit_handle;
    logic [7:0]  idx_handle;
    logic        remove_ok;
    logic        append_ok;
    logic        table_full;
    logic        too_short;
    logic [15:0] min_length;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.commit) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= s_data;
        end
        if (cmd.commit) begin
            out_reg          <= out_next;
            port_store_reg   <= port_store_next;
            handle_store_reg <= handle_store_next;
        end
    end

    // first live entry with a matching port decides
    always_comb begin
        hit_handle = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (COUNT_W'(i) < count_reg && port_store_reg[i] == req_reg.port) begin
                hit_handle = handle_store_reg[i];
            end
        end
    end

    always_comb begin
        idx_handle = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (CMP_W'(i) == CMP_W'(req_reg.entry_index)) begin
                idx_handle = handle_store_reg[i];
            end
        end
    end

    assign table_full = (count_reg == COUNT_W'(TABLE_DEPTH));
    assign remove_ok  = (req_reg.req_type == REQ_REMOVE)
                        && (CMP_W'(req_reg.entry_index) < CMP_W'(count_reg));
    assign append_ok  = (req_reg.req_type == REQ_REGISTER)
                        && (hit_handle == '0) && !table_full;
    assign min_length = 16'({req_reg.ip_header_words, 2'b00}) + 16'(UDP_HDR_BYTES);
    assign too_short  = req_reg.recv_length < min_length;

    // table update: append at the fill point, or shift down over a removed entry
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            port_store_next[i]   = port_store_reg[i];
            handle_store_next[i] = handle_store_reg[i];
            if (append_ok && COUNT_W'(i) == count_reg) begin
                port_store_next[i]   = req_reg.port;
                handle_store_next[i] = req_reg.handle;
            end
            if (remove_ok && i + 1 < TABLE_DEPTH
                && CMP_W'(i) >= CMP_W'(req_reg.entry_index)) begin
                port_store_next[i]   = port_store_reg[(i + 1) % TABLE_DEPTH];
                handle_store_next[i] = handle_store_reg[(i + 1) % TABLE_DEPTH];
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (append_ok) begin
            count_next = count_reg + 1'b1;
        end else if (remove_ok) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb begin
        out_next                 = '0;
        out_next.status          = STS_REGISTERED;
        out_next.entry_count     = OUT_COUNT_W'(count_next);
        dp_sts.has_result        = 1'b1;
        case (req_reg.req_type)
            REQ_REGISTER: begin
                out_next.conflict_handle = hit_handle;
                if (hit_handle != '0) begin
                    out_next.status = STS_IN_USE;
                end else if (table_full) begin
                    out_next.status = STS_FULL;
                end else begin
                    out_next.status = STS_REGISTERED;
                end
            end
            REQ_REMOVE: begin
                if (remove_ok) begin
                    out_next.status        = STS_REMOVED;
                    out_next.target_handle = idx_handle;
                end else begin
                    out_next.status = STS_BAD_INDEX;
                end
            end
            REQ_ROUTE: begin
                if (too_short) begin
                    out_next.status = STS_TOO_SHORT;
                end else if (req_reg.rx_checksum != req_reg.calc_checksum) begin
                    out_next.status = STS_BAD_CSUM;
                end else if (hit_handle == '0) begin
                    out_next.status = STS_NO_SERVER;
                end else if (req_reg.udp_length < 16'(UDP_HDR_BYTES)) begin
                    out_next.status = STS_EMPTY;
                end else begin
                    out_next.status         = STS_FORWARDED;
                    out_next.target_handle  = hit_handle;
                    out_next.payload_length = req_reg.udp_length - 16'(UDP_HDR_BYTES);
                end
            end
            default: begin
                dp_sts.has_result = 1'b0;
            end
        endcase
    end

    assign m_data = out_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_append_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && append_ok) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("append did not grow the table");

    a_remove_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && remove_ok) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("remove did not shrink the table");
`endif

endmodule
`default_nettype wire

/* hw/rtl/udp_port_dispatch_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udp_port_dispatch_table
// Compacting port-to-handle table for register, remove and route requests.
// ----------------------------------------------------------------------------
// Each request is first captured, then executed: the parallel lookup runs
// over all table entries, the table is updated and the result register is
// loaded. The input is taken again as soon as the request has been
// executed, even while its result still waits on m_ready; a request only
// stalls in execute when the previous result has not yet been taken. A
// request type of 3 is consumed and gives no result. The table needs no
// clearing after reset: only entries below the live count are ever read.
// ----------------------------------------------------------------------------
module udp_port_dispatch_table
    import udpd_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire udpd_in_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output udpd_out_t     m_data
);

    udpd_cmd_t cmd;
    udpd_sts_t dp_sts;

    udpd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dp_sts  (dp_sts),
        .cmd     (cmd)
    );

    udpd_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .dp_sts  (dp_sts),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire
